// File: rtl/core/bmar_pkg.sv
// Package for the block mean / absolute mean / RMS averager.
// Widths, mode and register codes, and the shared arithmetic unit's
// transaction types. No dependencies.
package bmar_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W   = 24;
  localparam int WIN_W      = 16;
  localparam int MODE_W     = 2;
  localparam int ACC_W      = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Window length after reset
  localparam logic [WIN_W-1:0] DEFAULT_WINDOW = 16'd100;

  // Averaging modes; the spare code behaves as the bipolar mean
  localparam logic [MODE_W-1:0] MODE_MEAN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ABS   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RMS   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b1;

  // Iteration counts of the divider and the square root
  localparam int DIV_STEPS  = ACC_W;
  localparam int SQRT_STEPS = ACC_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // Saturation limits of the result
  localparam logic [SAMPLE_W-1:0] SAT_HI = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAT_LO = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Request to and response from the shared add/subtract unit
  typedef struct packed {
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ACC_W-1:0] sum;
    logic             borrow;
  } alu_rsp_t;

endpackage

// File: rtl/core/bmar_alu.sv
// Shared 64-bit add/subtract unit with borrow flag.
// Used for accumulation, negation, divider and square-root steps.
// Depends on bmar_pkg.
module bmar_alu (
  input  bmar_pkg::alu_req_t req,
  output bmar_pkg::alu_rsp_t rsp
);
  import bmar_pkg::*;

  logic [ACC_W-1:0] b_op;
  logic [ACC_W:0]   total;

  // Invert and add one for subtraction; a missing carry means a borrow
  assign b_op       = req.sub ? ~req.b : req.b;
  assign total      = {1'b0, req.a} + {1'b0, b_op} + {{ACC_W{1'b0}}, req.sub};
  assign rsp.sum    = total[ACC_W-1:0];
  assign rsp.borrow = req.sub & ~total[ACC_W];

endmodule

// File: rtl/core/block_mean_abs_rms_averager.sv
// Channel      | ports                          | direction
// input        | in_valid, in_ready, in_sample  | sample in, one transaction per sample
// result       | out_valid, out_ready, out_average | held block average out
// config       | cfg_we, cfg_index, cfg_data    | register write, no read-back
//
// An item that does not close a window passes through the term, accumulate
// and output-load states; one that closes a window also passes through a
// magnitude state, one divider step per quotient bit and a negate state, then
// the square-root steps in RMS mode, then a saturation state. All steps share
// one 64-bit add/subtract unit. Synchronous active-low reset. A result waiting
// on out_ready holds the block only when the next result is ready to load.
module block_mean_abs_rms_averager (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [bmar_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bmar_pkg::SAMPLE_W-1:0] out_average,
  input  logic                                cfg_we,
  input  logic [bmar_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmar_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bmar_pkg::*;

  // Sequencer codes
  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
  localparam logic [ST_W-1:0] ST_TERM = 4'd1;
  localparam logic [ST_W-1:0] ST_ACC  = 4'd2;
  localparam logic [ST_W-1:0] ST_MAG  = 4'd3;
  localparam logic [ST_W-1:0] ST_DIV  = 4'd4;
  localparam logic [ST_W-1:0] ST_NEG  = 4'd5;
  localparam logic [ST_W-1:0] ST_SQRT = 4'd6;
  localparam logic [ST_W-1:0] ST_SAT  = 4'd7;
  localparam logic [ST_W-1:0] ST_OUT  = 4'd8;

  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);
  localparam logic [ACC_W-1:0]  BIT_INIT  = {2'b01, {(ACC_W-2){1'b0}}};

  logic [ST_W-1:0]            state_r, state_nxt;
  logic signed [SAMPLE_W-1:0] samp_r, samp_nxt;
  logic [ACC_W-1:0]           term_r, term_nxt;
  logic [ACC_W-1:0]           acc_r, acc_nxt;
  logic [WIN_W-1:0]           count_r, count_nxt;
  logic [WIN_W-1:0]           win_r, win_nxt;
  logic [MODE_W-1:0]          mode_r, mode_nxt;
  logic                       neg_r, neg_nxt;
  logic [WIN_W-1:0]           rem_r, rem_nxt;
  logic [ACC_W-1:0]           dvd_r, dvd_nxt;
  logic [ACC_W-1:0]           res_r, res_nxt;
  logic [ACC_W-1:0]           bit_r, bit_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [SAMPLE_W-1:0]        held_r, held_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]        out_average_r, out_average_nxt;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic signed [SAMPLE_W:0]     samp_ext;
  logic [SAMPLE_W:0]            abs_val;
  logic signed [2*SAMPLE_W-1:0] square;
  logic [WIN_W:0]               trial;
  logic [WIN_W-1:0]             count_plus;
  logic                         window_done;
  logic [ACC_W-1:0]             sat_in;
  logic                         sat_fits;

  bmar_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Per-mode term of the current sample
  assign samp_ext = {samp_r[SAMPLE_W-1], samp_r};
  assign abs_val  = samp_r[SAMPLE_W-1] ? (SAMPLE_W+1)'(-samp_ext) : samp_ext;
  assign square   = samp_r * samp_r;

  always_comb begin
    unique case (mode_r)
      MODE_ABS:   term_nxt = {{(ACC_W-SAMPLE_W-1){1'b0}}, abs_val};
      MODE_RMS:   term_nxt = {{(ACC_W-2*SAMPLE_W){square[2*SAMPLE_W-1]}}, square};
      MODE_MEAN,
      MODE_SPARE: term_nxt = {{(ACC_W-SAMPLE_W){samp_r[SAMPLE_W-1]}}, samp_r};
    endcase
  end

  // Window bookkeeping
  assign count_plus  = count_r + WIN_W'(1);
  assign window_done = (count_plus >= win_r) || (count_plus == '0);

  // Divider trial remainder
  assign trial = {rem_r, dvd_r[ACC_W-1]};

  // Saturate the finished value into the result range
  assign sat_in   = (mode_r == MODE_RMS) ? res_r : dvd_r;
  assign sat_fits = (&sat_in[ACC_W-1:SAMPLE_W-1]) | ~(|sat_in[ACC_W-1:SAMPLE_W-1]);

  // Operand selection for the shared unit
  always_comb begin
    alu_req.a   = acc_r;
    alu_req.b   = term_r;
    alu_req.sub = 1'b0;
    unique case (state_r)
      ST_MAG: begin
        alu_req.a   = '0;
        alu_req.b   = acc_r;
        alu_req.sub = 1'b1;
      end
      ST_DIV: begin
        alu_req.a   = {{(ACC_W-WIN_W-1){1'b0}}, trial};
        alu_req.b   = {{(ACC_W-WIN_W){1'b0}}, win_r};
        alu_req.sub = 1'b1;
      end
      ST_NEG: begin
        alu_req.a   = '0;
        alu_req.b   = dvd_r;
        alu_req.sub = 1'b1;
      end
      ST_SQRT: begin
        alu_req.a   = dvd_r;
        alu_req.b   = res_r | bit_r;
        alu_req.sub = 1'b1;
      end
      default: begin
        alu_req.a   = acc_r;
        alu_req.b   = term_r;
        alu_req.sub = 1'b0;
      end
    endcase
  end

  // Sequencer and datapath next values
  always_comb begin
    state_nxt       = state_r;
    samp_nxt        = samp_r;
    acc_nxt         = acc_r;
    count_nxt       = count_r;
    win_nxt         = win_r;
    mode_nxt        = mode_r;
    neg_nxt         = neg_r;
    rem_nxt         = rem_r;
    dvd_nxt         = dvd_r;
    res_nxt         = res_r;
    bit_nxt         = bit_r;
    step_nxt        = step_r;
    held_nxt        = held_r;
    out_valid_nxt   = out_valid_r & ~out_ready;
    out_average_nxt = out_average_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          samp_nxt  = in_sample;
          state_nxt = ST_TERM;
        end
      end
      ST_TERM: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt = alu_rsp.sum;
        if (window_done) begin
          count_nxt = '0;
          state_nxt = ST_MAG;
        end else begin
          count_nxt = count_plus;
          state_nxt = ST_OUT;
        end
      end
      ST_MAG: begin
        // Take the magnitude and clear the accumulator for the next window
        neg_nxt   = acc_r[ACC_W-1];
        dvd_nxt   = acc_r[ACC_W-1] ? alu_rsp.sum : acc_r;
        acc_nxt   = '0;
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // Restoring division, one quotient bit a cycle
        rem_nxt  = alu_rsp.borrow ? trial[WIN_W-1:0] : alu_rsp.sum[WIN_W-1:0];
        dvd_nxt  = {dvd_r[ACC_W-2:0], ~alu_rsp.borrow};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == DIV_LAST) begin
          state_nxt = ST_NEG;
        end
      end
      ST_NEG: begin
        if (neg_r) begin
          dvd_nxt = alu_rsp.sum;
        end
        res_nxt  = '0;
        bit_nxt  = BIT_INIT;
        step_nxt = '0;
        state_nxt = (mode_r == MODE_RMS) ? ST_SQRT : ST_SAT;
      end
      ST_SQRT: begin
        // Digit-by-digit square root, two radicand bits a cycle
        if (!alu_rsp.borrow) begin
          dvd_nxt = alu_rsp.sum;
          res_nxt = (res_r >> 1) | bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt  = bit_r >> 2;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == SQRT_LAST) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        if (sat_fits) begin
          held_nxt = sat_in[SAMPLE_W-1:0];
        end else begin
          held_nxt = sat_in[ACC_W-1] ? SAT_LO : SAT_HI;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // Load the output register once it is free or being taken
        if (!out_valid_r || out_ready) begin
          out_average_nxt = held_r;
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Register writes; a zero window length is dropped
    if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW: begin
          if (cfg_data[WIN_W-1:0] != '0) begin
            win_nxt   = cfg_data[WIN_W-1:0];
            count_nxt = '0;
            acc_nxt   = '0;
          end
        end
        REG_MODE: begin
          mode_nxt  = cfg_data[MODE_W-1:0];
          count_nxt = '0;
          acc_nxt   = '0;
        end
      endcase
    end
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      count_r     <= '0;
      win_r       <= DEFAULT_WINDOW;
      mode_r      <= MODE_MEAN;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      count_r     <= count_nxt;
      win_r       <= win_nxt;
      mode_r      <= mode_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    samp_r        <= samp_nxt;
    term_r        <= term_nxt;
    neg_r         <= neg_nxt;
    rem_r         <= rem_nxt;
    dvd_r         <= dvd_nxt;
    res_r         <= res_nxt;
    bit_r         <= bit_nxt;
    step_r        <= step_nxt;
    out_average_r <= out_average_nxt;
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

endmodule

// File: rtl/core/bmar_checker.sv
// Port-level checker for the block averager, bound to the top level.
// Depends on bmar_pkg and block_mean_abs_rms_averager.
module bmar_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bmar_pkg::SAMPLE_W-1:0] out_average
);
  import bmar_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average))
    else $error("result changed or dropped while stalled");

  // Stay busy for the term, accumulate and load cycles after a transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input taken while a sample is still in work");

  // Raise a result only out of a busy cycle
  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result raised without a sample in work");

  // Come out of reset idle with no result pending
  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind block_mean_abs_rms_averager bmar_checker u_bmar_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_average (out_average)
);

// File: tb/tb_top.sv
// Self-checking testbench for block_mean_abs_rms_averager: directed and random samples
// through a valid/ready channel, each result checked against an in-bench predictor.
// Depends on bmar_pkg and the block's RTL only.
module tb_top;
  import bmar_pkg::*;

  localparam int    CYCLE_LIMIT = 1_500_000;
  localparam int    TAIL_CYCLES = 120;
  localparam longint AVG_MAX    = 2 ** (SAMPLE_W - 1) - 1;
  localparam longint AVG_MIN    = -(2 ** (SAMPLE_W - 1));
  localparam logic signed [SAMPLE_W-1:0] FULL_POS = SAT_HI;
  localparam logic signed [SAMPLE_W-1:0] FULL_NEG = SAT_LO;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  logic signed [SAMPLE_W-1:0]   in_sample = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0]   out_average;
  logic                         cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = REG_WINDOW;
  logic [CFG_DATA_W-1:0]        cfg_data  = '0;

  // Predictor state, kept in step with the block's registers
  logic [WIN_W-1:0]             win_len;
  logic [MODE_W-1:0]            avg_mode;
  longint                       acc;
  logic [WIN_W-1:0]             fill;
  logic signed [SAMPLE_W-1:0]   held;
  logic signed [SAMPLE_W-1:0]   expected_averages[$];
  logic signed [SAMPLE_W-1:0]   due_average;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors        = 0;
  int cycles        = 0;

  block_mean_abs_rms_averager DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_average(out_average),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_failure(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Floor square root, one result bit at a time from the top
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic void reset_predictor();
    win_len  = DEFAULT_WINDOW;
    avg_mode = MODE_MEAN;
    acc      = 0;
    fill     = '0;
    held     = '0;
  endfunction

  // Take one sample in and return the average held afterwards
  function automatic logic signed [SAMPLE_W-1:0] take_sample(
      input logic signed [SAMPLE_W-1:0] s);
    longint sv;
    longint n;
    longint q;
    sv = s;
    n  = win_len;
    case (avg_mode)
      MODE_ABS: acc += (sv < 0) ? -sv : sv;
      MODE_RMS: acc += sv * sv;
      default:  acc += sv;
    endcase
    fill = fill + 1'b1;
    if (fill >= win_len || fill == '0) begin
      q = acc / n;
      if (avg_mode == MODE_RMS) q = longint'(floor_root(longint'(q)));
      if (q > AVG_MAX) q = AVG_MAX;
      if (q < AVG_MIN) q = AVG_MIN;
      held = q[SAMPLE_W-1:0];
      fill = '0;
      acc  = 0;
    end
    return held;
  endfunction

  // Send one sample transaction, idling first at the current sender rate
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_averages.push_back(take_sample(s));
  endtask

  // Hold the sender until every expected result has been taken
  task automatic wait_for_drain();
    if (in_valid) in_valid <= 1'b0;
    while (expected_averages.size() != 0) @(posedge clk);
  endtask

  task automatic write_regs(input bit set_win, input logic [CFG_DATA_W-1:0] win,
                            input bit set_mode, input logic [CFG_DATA_W-1:0] mode_word);
    wait_for_drain();
    if (set_win) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_WINDOW;
      cfg_data  <= win;
      @(posedge clk);
      // A zero length is ignored and leaves the partial window alone
      if (win != '0) begin
        win_len = win;
        fill    = '0;
        acc     = 0;
      end
    end
    if (set_mode) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_MODE;
      cfg_data  <= mode_word;
      @(posedge clk);
      avg_mode = mode_word[MODE_W-1:0];
      fill     = '0;
      acc      = 0;
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return FULL_POS;
      1:       return FULL_NEG;
      2:       return SAMPLE_W'($urandom_range(64)) - SAMPLE_W'(32);
      3:       return SAMPLE_W'($urandom_range(4095)) - SAMPLE_W'(2048);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Check each result transaction against the oldest expectation; drive ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_averages.size() == 0) begin
        report_failure($sformatf("result %0d with nothing expected", out_average));
      end else begin
        due_average = expected_averages.pop_front();
        if (out_average !== due_average)
          report_failure($sformatf("average got %0d want %0d", out_average, due_average));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Window length and mode straight after reset
  task automatic test_default_window();
    for (int i = 0; i < 100; i++) send_sample(pick_sample());
  endtask

  // Full-scale samples in the mean, absolute and RMS modes, one-sample windows
  task automatic test_full_scale();
    write_regs(1'b1, 16'd1, 1'b1, {14'd0, MODE_MEAN});
    send_sample(FULL_POS);
    send_sample(FULL_NEG);
    send_sample('0);
    send_sample(-24'sd1);
    send_sample(24'sd1);
    // absolute mean of the most negative sample saturates
    write_regs(1'b0, '0, 1'b1, {14'd0, MODE_ABS});
    send_sample(FULL_NEG);
    send_sample(FULL_POS);
    // root mean square of the most negative sample saturates
    write_regs(1'b0, '0, 1'b1, {14'd0, MODE_RMS});
    send_sample(FULL_NEG);
    send_sample(FULL_POS);
    send_sample(-24'sd1);
    send_sample('0);
  endtask

  // Truncation toward zero, floor root, and the spare mode code
  task automatic test_rounding();
    write_regs(1'b1, 16'd2, 1'b1, {14'd0, MODE_SPARE});
    send_sample(-24'sd5);
    send_sample(24'sd2);
    write_regs(1'b1, 16'd3, 1'b1, {14'd0, MODE_MEAN});
    send_sample(-24'sd1);
    send_sample(-24'sd1);
    send_sample('0);
    write_regs(1'b1, 16'd2, 1'b1, {14'h3fff, MODE_RMS});
    send_sample(24'sd3);
    send_sample('0);
  endtask

  // A zero window length leaves length, count and sum untouched
  task automatic test_zero_window();
    write_regs(1'b1, 16'd5, 1'b1, {14'd0, MODE_ABS});
    send_sample(-24'sd700);
    send_sample(24'sd1300);
    send_sample(-24'sd9);
    write_regs(1'b1, 16'd0, 1'b0, '0);
    send_sample(24'sd40);
    send_sample(-24'sd2);
  endtask

  // Longest window: the held value must stay put
  task automatic test_max_window();
    write_regs(1'b1, 16'hffff, 1'b1, {14'h2aaa, MODE_RMS});
    for (int i = 0; i < 20; i++) send_sample(pick_sample());
  endtask

  // Random samples under random settings, mostly short windows
  task automatic test_random(input int count);
    int             left;
    int             pick;
    bit             set_win;
    bit             set_mode;
    logic [WIN_W-1:0] win;
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        pick = $urandom_range(99);
        if (pick < 60)      win = WIN_W'($urandom_range(8, 1));
        else if (pick < 90) win = WIN_W'($urandom_range(64, 9));
        else if (pick < 98) win = WIN_W'($urandom_range(400, 65));
        else                win = WIN_W'($urandom);
        set_win  = ($urandom_range(3) != 0);
        set_mode = ($urandom_range(3) != 0);
        if (!set_win && !set_mode) set_mode = 1'b1;
        write_regs(set_win, win, set_mode, CFG_DATA_W'($urandom));
        left = $urandom_range(80, 20);
      end
      // now and then let the block empty completely before the next sample
      if ($urandom_range(49) == 0) wait_for_drain();
      send_sample(pick_sample());
      left--;
    end
  endtask

  initial begin
    reset_predictor();
    send_idle_pct = 21;
    recv_idle_pct = 77;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_default_window();
    test_full_scale();
    test_rounding();
    test_zero_window();
    test_max_window();
    test_random(430);

    send_idle_pct = 77;
    recv_idle_pct = 21;
    test_random(430);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(430);

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_averages.size() != 0)
      report_failure($sformatf("%0d results never arrived", expected_averages.size()));
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
